// File: rtl/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_ADDRESS_BITS      = 48;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int LEN_W        = 5;
    localparam int PAT_IDX_W    = 4;
    localparam int PAT_BYTES    = 16;
    localparam int RANGE_W      = 48;
    localparam int MATCH_ADDR_W = 48;
    localparam int BYTE_W       = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_RANGE_START  = 3'd4,
        REG_RANGE_LEN    = 3'd5
    } cfg_reg_t;

    // what one window cell compares against
    typedef struct packed {
        logic [BYTE_W-1:0] pat_byte;
        logic              wild;
        logic              used;
    } lane_cfg_t;

endpackage

// File: rtl/wbps_cell.sv
`timescale 1ns / 1ps

module wbps_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  logic [7:0]               prev_byte,
    input  logic                     prev_valid,
    input  wbps_pkg::lane_cfg_t      lane,
    output logic [7:0]               cell_byte,
    output logic                     cell_valid,
    output logic                     lane_ok
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;
    logic              valid_next;

    assign valid_next = shift ? prev_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= prev_byte;
        end
    end

    assign cell_byte  = byte_reg;
    assign cell_valid = valid_reg;
    // lanes beyond the pattern length always agree
    assign lane_ok = !lane.used || (valid_reg && (lane.wild || (byte_reg == lane.pat_byte)));

endmodule

// File: rtl/wbps_range.sv
`timescale 1ns / 1ps

module wbps_range #(
    parameter int ADDRESS_BITS = wbps_pkg::DEF_ADDRESS_BITS
) (
    input  logic [ADDRESS_BITS-1:0]   addr,
    input  logic [wbps_pkg::LEN_W-1:0] len_eff,
    input  logic [ADDRESS_BITS-1:0]   range_start,
    input  logic [ADDRESS_BITS-1:0]   range_length,
    output logic                      in_range,
    output logic [ADDRESS_BITS-1:0]   first_addr
);
    import wbps_pkg::*;

    logic [ADDRESS_BITS-1:0] back;
    logic [ADDRESS_BITS-1:0] room;
    logic [ADDRESS_BITS-1:0] span;
    logic [ADDRESS_BITS-1:0] end_addr;

    assign back = ADDRESS_BITS'(len_eff - LEN_W'(1));

    // range end saturates at the top address
    assign room     = ~range_start;
    assign span     = (range_length < room) ? range_length : room;
    assign end_addr = range_start + span;

    assign first_addr = addr - back;
    assign in_range   = (addr >= back) && (first_addr >= range_start) && (addr < end_addr);

endmodule

// File: rtl/wildcard_byte_pattern_scanner.sv
`timescale 1ns / 1ps

// Wildcard byte pattern scanner. Each input word carries one memory byte and
// its address (tdata) and a block-begin flag (tuser) that empties the window.
// The bytes shift through a row of MAX_PATTERN_BYTES cells; each cell compares
// its byte with the pattern byte aligned to it, masked positions match
// anything, and a hit is reported with the address of the first pattern byte
// only when the whole match lies inside the configured range. Every input word
// gives exactly one output word. One word is taken per clock unless the output
// stalls; a word shifts into the window, then compare and range check load the
// output register. The user writes configuration only while no word is in
// flight; the block does not enforce it. The config channel is always ready.

module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int ADDRESS_BITS      = wbps_pkg::DEF_ADDRESS_BITS,
    localparam int S_DATA_W         = ((8 + ADDRESS_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte [7:0], byte_address [ADDRESS_BITS+7:8], zero fill above
    input  logic [S_DATA_W-1:0]               s_tdata,
    // block_begin
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // match_address
    output logic [wbps_pkg::MATCH_ADDR_W-1:0] m_tdata,
    // match_found
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import wbps_pkg::*;

    // configuration registers
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [PAT_BYTES-1:0]  wild_reg;
    logic [LEN_W-1:0]      plen_reg;
    logic [RANGE_W-1:0]    rstart_reg;
    logic [RANGE_W-1:0]    rlen_reg;

    logic cfg_accept;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            plen_reg     <= LEN_W'(1);
            rstart_reg   <= '0;
            rlen_reg     <= '1;
        end
        else if (cfg_accept)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_WILDCARD:     wild_reg     <= cfg_data[PAT_BYTES-1:0];
                REG_PATTERN_LEN:  plen_reg     <= cfg_data[LEN_W-1:0];
                REG_RANGE_START:  rstart_reg   <= cfg_data[RANGE_W-1:0];
                REG_RANGE_LEN:    rlen_reg     <= cfg_data[RANGE_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective pattern length, 1 .. MAX_PATTERN_BYTES
    logic [LEN_W-1:0] len_eff;
    always_comb
    begin
        priority if (plen_reg == '0)
            len_eff = LEN_W'(1);
        else if (plen_reg > LEN_W'(MAX_PATTERN_BYTES))
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        else
            len_eff = plen_reg;
    end

    logic [2*CFG_DATA_W-1:0] pat_all;
    assign pat_all = {pat_high_reg, pat_low_reg};

    // handshake and pipeline control
    logic                    s_accept;
    logic                    advance;
    logic                    p1_valid_reg;
    logic                    p1_valid_next;
    logic [ADDRESS_BITS-1:0] p1_addr_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    found_reg;
    logic [MATCH_ADDR_W-1:0] maddr_reg;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    logic [BYTE_W-1:0]       in_byte;
    logic [ADDRESS_BITS-1:0] in_addr;
    assign in_byte = s_tdata[BYTE_W-1:0];
    assign in_addr = s_tdata[BYTE_W +: ADDRESS_BITS];

    // window cells, cell 0 holds the newest byte
    logic [BYTE_W-1:0]            cell_byte [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_valid;
    logic [MAX_PATTERN_BYTES-1:0] lane_ok;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_cell
        logic [BYTE_W-1:0] prev_byte;
        logic              prev_valid;
        logic [LEN_W-1:0]  pidx;
        lane_cfg_t         lane;

        if (k == 0)
        begin : g_head
            assign prev_byte  = in_byte;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_byte  = cell_byte[k-1];
            assign prev_valid = cell_valid[k-1] && !s_tuser;
        end

        // cell k sees the byte that pattern byte len-1-k must match
        assign pidx          = len_eff - LEN_W'(k) - LEN_W'(1);
        assign lane.pat_byte = pat_all[pidx[PAT_IDX_W-1:0]*BYTE_W +: BYTE_W];
        assign lane.wild     = wild_reg[pidx[PAT_IDX_W-1:0]];
        assign lane.used     = LEN_W'(k) < len_eff;

        wbps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (s_accept),
            .prev_byte  (prev_byte),
            .prev_valid (prev_valid),
            .lane       (lane),
            .cell_byte  (cell_byte[k]),
            .cell_valid (cell_valid[k]),
            .lane_ok    (lane_ok[k])
        );
    end

    // range check on the word sitting in stage one
    logic [63:0]             rstart_wide;
    logic [63:0]             rlen_wide;
    logic                    in_range;
    logic [ADDRESS_BITS-1:0] first_addr;
    logic [63:0]             first_wide;
    logic                    hit;

    assign rstart_wide = 64'(rstart_reg);
    assign rlen_wide   = 64'(rlen_reg);

    wbps_range #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_range (
        .addr         (p1_addr_reg),
        .len_eff      (len_eff),
        .range_start  (rstart_wide[ADDRESS_BITS-1:0]),
        .range_length (rlen_wide[ADDRESS_BITS-1:0]),
        .in_range     (in_range),
        .first_addr   (first_addr)
    );

    assign first_wide = 64'(first_addr);
    assign hit        = (&lane_ok) && in_range;

    assign p1_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : p1_valid_reg);
    assign m_valid_next  = advance ? p1_valid_reg : m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p1_addr_reg <= in_addr;
        end
        if (advance && p1_valid_reg)
        begin
            found_reg <= hit;
            maddr_reg <= hit ? first_wide[MATCH_ADDR_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = maddr_reg;
    assign m_tuser  = found_reg;

    // a word with no match carries a zero address
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("output address not zero without a match");

    // stage one never takes a word while it is full and the output is stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is blocked");

    // a block start leaves only the newest cell filled
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser) |=> ($countones(cell_valid) == 1) && cell_valid[0])
        else $error("window not emptied at block start");

    // filled cells always form a run from the newest byte
    a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + MAX_PATTERN_BYTES'(1))) == '0))
        else $error("window fill bits are not contiguous");

endmodule

// File: tb/wildcard_byte_pattern_scanner_test.sv
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_test;

    import wbps_pkg::*;

    localparam int ADDR_W          = DEF_ADDRESS_BITS;
    localparam int S_DATA_W        = ((8 + ADDR_W + 7) / 8) * 8;
    localparam logic [ADDR_W-1:0] TOP_ADDR = '1;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_CYCLES     = 200;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 165;

    // indexes the block has no register for
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } match_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [MATCH_ADDR_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies as the scanner sees them
    logic [63:0]       pat_low   = '0;
    logic [63:0]       pat_high  = '0;
    logic [15:0]       wild_mask = '0;
    logic [LEN_W-1:0]  pat_len   = 5'd1;
    logic [ADDR_W-1:0] rng_start = '0;
    logic [ADDR_W-1:0] rng_len   = TOP_ADDR;

    logic [7:0] window [PAT_BYTES];
    int         window_fill = 0;

    match_t pending_matches[$];
    int     error_count   = 0;
    bit     hold_request  = 0;
    bit     sink_stalls   = 1;

    wildcard_byte_pattern_scanner dut (.*);

    always #2 clk = ~clk;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic int eff_len();
        if (pat_len == '0)
            return 1;
        if (pat_len > LEN_W'(PAT_BYTES))
            return PAT_BYTES;
        return int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_byte(int j);
        logic [127:0] p;
        p = {pat_high, pat_low};
        return p[j*8 +: 8];
    endfunction

    // last address a match may cover, plus one; saturates at the top address
    function automatic logic [ADDR_W-1:0] range_end();
        logic [ADDR_W-1:0] room;
        room = TOP_ADDR - rng_start;
        return rng_start + ((rng_len < room) ? rng_len : room);
    endfunction

    function automatic match_t scan_predict(input logic [7:0] b, input logic [ADDR_W-1:0] a,
                                            input logic first);
        match_t            res;
        int                n;
        bit                hit;
        logic [ADDR_W-1:0] start_addr;
        n = eff_len();
        if (first)
        begin
            for (int j = 0; j < PAT_BYTES; j++)
                window[j] = '0;
            window_fill = 0;
        end
        for (int j = PAT_BYTES - 1; j > 0; j--)
            window[j] = window[j-1];
        window[0] = b;
        if (window_fill < PAT_BYTES)
            window_fill++;
        hit = (window_fill >= n);
        for (int j = 0; j < n; j++)
            if (!wild_mask[j] && pat_byte(j) != window[n-1-j])
                hit = 0;
        res = '0;
        start_addr = a - ADDR_W'(n - 1);
        if (hit && a >= ADDR_W'(n - 1) && start_addr >= rng_start && a < range_end())
        begin
            res.found = 1'b1;
            res.addr  = start_addr;
        end
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PATTERN_LOW:  pat_low   = value;
            REG_PATTERN_HIGH: pat_high  = value;
            REG_WILDCARD:     wild_mask = value[15:0];
            REG_PATTERN_LEN:  pat_len   = value[LEN_W-1:0];
            REG_RANGE_START:  rng_start = value[ADDR_W-1:0];
            REG_RANGE_LEN:    rng_len   = value[ADDR_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // leaves tvalid high so the next word can follow without a gap
    task automatic push_byte(input logic [7:0] b, input logic [ADDR_W-1:0] a,
                             input logic first);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({a, b});
        s_tuser  <= first;
        do @(posedge clk); while (!s_tready);
        pending_matches.insert(pending_matches.size(), scan_predict(b, a, first));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        match_t exp_match;
        if (m_tvalid && m_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected word: match_found %0b match_address %h", m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                exp_match = pending_matches.pop_front();
                if (m_tuser !== exp_match.found)
                begin
                    $error("match_found: expected %0b, actual %0b", exp_match.found, m_tuser);
                    error_count++;
                end
                if (m_tdata !== exp_match.addr)
                begin
                    $error("match_address: expected %h, actual %h", exp_match.addr, m_tdata);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 0;
                stall_left = 0;
            end
            else
            begin
                if (stall_left == 0 && sink_stalls && $urandom_range(0, 2) == 0)
                    stall_left = rand_gap();
                if (stall_left > 0)
                begin
                    m_tready <= 1'b0;
                    stall_left--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // registers at reset: one-byte pattern of zero over the whole space
    task automatic test_reset_state();
        push_byte(8'h00, 0, 1);
        push_byte(8'hFF, 1, 0);
        push_byte(8'h00, TOP_ADDR, 0);
        wait_idle();
    endtask

    task automatic test_directed_patterns();
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_FF00_CDAB);
        write_reg(REG_WILDCARD, 64'h0004);
        write_reg(REG_PATTERN_LEN, 64'd4);
        push_byte(8'hAB, 0, 1);
        push_byte(8'hCD, 1, 0);
        push_byte(8'h5A, 2, 0);
        push_byte(8'hFF, 3, 0);
        // a new block cuts a would-be match in half
        push_byte(8'hAB, 200, 1);
        push_byte(8'hCD, 201, 0);
        push_byte(8'h00, 202, 1);
        push_byte(8'hFF, 203, 0);
        // repeated addresses; the match would begin below address zero
        push_byte(8'hAB, 0, 1);
        push_byte(8'hCD, 0, 0);
        push_byte(8'h00, 1, 0);
        push_byte(8'hFF, 2, 0);
        // ending on the top address is out of range, one lower is fine
        push_byte(8'hAB, TOP_ADDR - 3, 1);
        push_byte(8'hCD, TOP_ADDR - 2, 0);
        push_byte(8'hFF, TOP_ADDR - 1, 0);
        push_byte(8'hFF, TOP_ADDR, 0);
        push_byte(8'hAB, TOP_ADDR - 4, 1);
        push_byte(8'hCD, TOP_ADDR - 3, 0);
        push_byte(8'h00, TOP_ADDR - 2, 0);
        push_byte(8'hFF, TOP_ADDR - 1, 0);
        wait_idle();
        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        // length field of zero behaves as one; upper data bits are dropped
        write_reg(REG_PATTERN_LEN, 64'd32);
        write_reg(REG_RANGE_START, 64'hFFFF_0000_0000_0005);
        write_reg(REG_RANGE_LEN, 64'hABCD_0000_0000_0001);
        push_byte(8'hAB, 4, 1);
        push_byte(8'hAB, 5, 0);
        push_byte(8'hAB, 6, 0);
        wait_idle();
    endtask

    // sink holds off while words keep coming, so the input must stall
    task automatic test_backpressure();
        logic [ADDR_W-1:0] base;
        write_reg(REG_RANGE_START, 64'd0);
        write_reg(REG_RANGE_LEN, 64'(TOP_ADDR));
        write_reg(REG_PATTERN_LEN, 64'd2);
        base = rand_addr();
        hold_request = 1;
        for (int k = 0; k < 48; k++)
            push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : pat_byte(k % 2),
                      base + ADDR_W'(k), k == 0);
        wait_idle();
    endtask

    task automatic test_random_scans();
        int                n_sent, n, blk_len, plant_pos, gap;
        bit                sender_gaps, noise, first;
        logic [63:0]       len_val, mask_val, rs_val, rl_val;
        logic [ADDR_W-1:0] a;
        logic [7:0]        b;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    len_val = 1;  mask_val = 0;      rs_val = 0;
                    rl_val = 64'(TOP_ADDR);
                end
                1:
                begin
                    len_val = 16; mask_val = 64'($urandom & $urandom);
                    rs_val = 64'(TOP_ADDR); rl_val = 64'(rand_addr());
                end
                2:
                begin
                    len_val = 64'hFFFF_FFFF_FFFF_FFE0; mask_val = 0;
                    rs_val = 64'(rand_addr()); rl_val = 0;
                end
                3:
                begin
                    len_val = 31; mask_val = 16'hFFFF;
                    rs_val = 64'($urandom_range(0, 100)); rl_val = 64'(TOP_ADDR);
                end
                default:
                begin
                    len_val  = 64'($urandom_range(0, 1) ? $urandom_range(1, 4)
                                                        : $urandom_range(1, 16));
                    mask_val = 64'($urandom & $urandom & $urandom);
                    rs_val   = $urandom_range(0, 1) ? 64'(rand_addr())
                                                    : 64'($urandom_range(0, 300));
                    rl_val   = $urandom_range(0, 1) ? 64'($urandom_range(0, 400))
                                                    : 64'(rand_addr());
                end
            endcase
            // garbage above each register's width must be ignored
            write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
            write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
            write_reg(REG_WILDCARD, {32'($urandom), 16'($urandom), mask_val[15:0]});
            write_reg(REG_PATTERN_LEN, len_val);
            write_reg(REG_RANGE_START, {16'($urandom), rs_val[ADDR_W-1:0]});
            write_reg(REG_RANGE_LEN, {16'($urandom), rl_val[ADDR_W-1:0]});
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
            sink_stalls = (phase % 4 != 1);
            sender_gaps = (phase % 4 != 2);
            n = eff_len();
            n_sent = 0;
            while (n_sent < ITEMS_PER_PHASE)
            begin
                blk_len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 50)
                                                      : $urandom_range(1, 20);
                case ($urandom_range(0, 4))
                    0: a = rand_addr();
                    1: a = rng_start - ADDR_W'($urandom_range(0, 20));
                    2: a = range_end() - ADDR_W'($urandom_range(0, 30));
                    3: a = ADDR_W'($urandom_range(0, 20));
                    default: a = TOP_ADDR - ADDR_W'($urandom_range(0, 40));
                endcase
                noise = ($urandom_range(0, 9) == 0);
                plant_pos = -1;
                for (int k = 0; k < blk_len; k++)
                begin
                    if (plant_pos < 0 && $urandom_range(0, 3) == 0)
                        plant_pos = 0;
                    if (plant_pos >= 0)
                    begin
                        b = wild_mask[plant_pos] ? 8'($urandom) : pat_byte(plant_pos);
                        plant_pos = (plant_pos + 1 == n) ? -1 : plant_pos + 1;
                    end
                    else
                        b = $urandom_range(0, 1) ? 8'($urandom)
                                                 : pat_byte($urandom_range(0, n - 1));
                    first = (k == 0) ? ($urandom_range(0, 15) != 0)
                                     : (noise && $urandom_range(0, 19) == 0);
                    push_byte(b, a, first);
                    n_sent++;
                    // broken blocks skip or repeat addresses
                    if (noise && $urandom_range(0, 5) == 0)
                        a = a + ADDR_W'($urandom_range(0, 6));
                    else
                        a = a + 1'b1;
                    gap = sender_gaps ? rand_gap() : 0;
                    if (gap > 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_patterns();
        test_backpressure();
        test_random_scans();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
